// ===== rtl/sync_checksum_packet_deframer_unit_assert.svh =====
`ifndef SYNC_CHECKSUM_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define SYNC_CHECKSUM_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define SCDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scdf assertion failed");

// next-cycle implication
`define SCDF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scdf assertion failed");

`endif

// ===== rtl/scdf_pkg.sv =====
package scdf_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int MEM_DEPTH    = 2 * BUFFER_DEPTH;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam int FL_MAX_INT   = (BUFFER_DEPTH > 127) ? 127 : BUFFER_DEPTH;

    localparam logic [6:0] FL_MIN = 7'd2;
    localparam logic [6:0] FL_MAX = 7'(FL_MAX_INT);

    localparam logic [6:0] FRAME_LENGTH_RST = 7'd16;
    localparam logic [7:0] FIRST_SYNC_RST   = 8'h81;
    localparam logic [7:0] SECOND_SYNC_RST  = 8'h55;

    localparam logic [1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [1:0] CFG_FIRST_SYNC   = 2'd1;
    localparam logic [1:0] CFG_SECOND_SYNC  = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       frame_done;
        logic       checksum_ok;
        logic       data_valid;
        logic [1:0] rx_phase;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    typedef struct packed {
        logic              re;
        logic [MEM_AW-1:0] addr;
    } rd_t;

    typedef struct packed {
        logic   mode;
        logic   rd_ok;
        logic   frame_done;
        logic   checksum_ok;
        logic   data_valid;
        phase_t phase;
    } status_t;

endpackage

// ===== rtl/sync_checksum_packet_deframer_unit.sv =====
// Each item's status passes stage 1, then the output register; a read item's RAM data joins it there.
// One item per cycle unless stalled; data-phase bytes are RAM writes, read items RAM reads.
// The stall chain is one intermediate stage plus the output register.
// Reset: rst_n async low clears phase, counters, bank select, valid flag, per-entry
// valid bits (never-written entries read as zero) and loads the config defaults.
module sync_checksum_packet_deframer_unit
    import scdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

`include "sync_checksum_packet_deframer_unit_assert.svh"

    logic       accept;
    wr_t        wr;
    rd_t        rd;
    status_t    st;
    logic [7:0] ram_rdata;

    logic    s1_valid_reg, s1_valid_next;
    status_t s1_st_reg;
    logic    s1_adv;
    logic    res_valid_reg, res_valid_next;
    res_t    res_reg, res_next;

    assign cfg_ready  = 1'b1;
    assign item_stall = s1_valid_reg && res_valid_reg && res_stall;
    assign accept     = item_valid && !item_stall;

    scdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (wr),
        .rd        (rd),
        .st        (st)
    );

    scdf_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.re),
        .raddr (rd.addr),
        .rdata (ram_rdata)
    );

    assign s1_adv         = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign res_valid_next = s1_adv || (res_valid_reg && res_stall);

    always_comb
    begin
        res_next.read_data   = (s1_st_reg.mode && s1_st_reg.rd_ok) ? ram_rdata : 8'd0;
        res_next.frame_done  = s1_st_reg.frame_done;
        res_next.checksum_ok = s1_st_reg.checksum_ok;
        res_next.data_valid  = s1_st_reg.data_valid;
        res_next.rx_phase    = s1_st_reg.phase;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_st_reg <= st;
        end
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `SCDF_ASSERT_IMP(a_wr_only_rx, clk, rst_n, wr.we, accept && !item.mode)
    `SCDF_ASSERT_IMP(a_done_flag, clk, rst_n, s1_valid_reg && s1_st_reg.frame_done,
        s1_st_reg.data_valid == s1_st_reg.checksum_ok)
    `SCDF_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_adv, s1_valid_reg)
    `SCDF_ASSERT_NXT(a_read_tracked, clk, rst_n, accept && item.mode,
        s1_valid_reg && s1_st_reg.mode)

endmodule

// ===== rtl/scdf_ram.sv =====
module scdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/scdf_ctrl.sv =====
module scdf_ctrl
    import scdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  item_t      item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output wr_t        wr,
    output rd_t        rd,
    output status_t    st
);

    logic [6:0]           frame_length_reg;
    logic [7:0]           first_sync_reg;
    logic [7:0]           second_sync_reg;
    phase_t               phase_reg, phase_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic [7:0]           sum_reg, sum_next;
    logic                 bank_reg, bank_next;
    logic                 vflag_reg, vflag_next;
    logic [MEM_DEPTH-1:0] vld_reg;

    logic              we_raw;
    logic [MEM_AW-1:0] waddr;
    logic [MEM_AW-1:0] raddr;
    logic [6:0]        len;
    logic [6:0]        cnt_inc;
    logic              done;
    logic              ok;
    logic              in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LENGTH_RST;
            first_sync_reg   <= FIRST_SYNC_RST;
            second_sync_reg  <= SECOND_SYNC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_LENGTH: frame_length_reg <= cfg_data[6:0];
                CFG_FIRST_SYNC:   first_sync_reg   <= cfg_data;
                CFG_SECOND_SYNC:  second_sync_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            bank_reg  <= 1'b0;
            vflag_reg <= 1'b0;
            vld_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            bank_reg  <= bank_next;
            vflag_reg <= vflag_next;
            if (we_raw)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        bank_next  = bank_reg;
        vflag_next = vflag_reg;
        we_raw     = 1'b0;
        done       = 1'b0;
        ok         = 1'b0;
        cnt_inc    = cnt_reg + 7'd1;

        if (frame_length_reg < FL_MIN)
            len = FL_MIN;
        else if (frame_length_reg > FL_MAX)
            len = FL_MAX;
        else
            len = frame_length_reg;

        waddr = bank_reg ? MEM_AW'(cnt_reg) : MEM_AW'(BUFFER_DEPTH) + MEM_AW'(cnt_reg);

        if (!item.mode)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    if (item.rx_byte == second_sync_reg)
                    begin
                        sum_next   = sum_reg + item.rx_byte;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    we_raw   = (cnt_reg < len);
                    cnt_next = cnt_inc;
                    if (cnt_inc >= len)
                    begin
                        done       = 1'b1;
                        phase_next = PH_HUNT;
                        if (item.rx_byte == sum_reg)
                        begin
                            ok         = 1'b1;
                            bank_next  = ~bank_reg;
                            vflag_next = 1'b1;
                        end
                        else
                        begin
                            vflag_next = 1'b0;
                        end
                    end
                    else
                    begin
                        sum_next = sum_reg + item.rx_byte;
                    end
                end
                default:
                begin
                    cnt_next   = '0;
                    sum_next   = item.rx_byte;
                    phase_next = (item.rx_byte == first_sync_reg) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    assign raddr = bank_reg ? MEM_AW'(BUFFER_DEPTH) + MEM_AW'(item.read_index)
                            : MEM_AW'(item.read_index);
    assign in_range = (32'(item.read_index) < BUFFER_DEPTH);

    assign wr.we   = accept && we_raw;
    assign wr.addr = waddr;
    assign wr.data = item.rx_byte;

    assign rd.re   = accept && item.mode;
    assign rd.addr = raddr;

    assign st.mode        = item.mode;
    assign st.rd_ok       = in_range && vld_reg[raddr];
    assign st.frame_done  = done;
    assign st.checksum_ok = ok;
    assign st.data_valid  = vflag_next;
    assign st.phase       = phase_next;

endmodule
